// File: hdl/assert_macros.svh
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, held off while in reset.
`define ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/bacr_pkg.sv
`timescale 1ns / 1ps

package bacr_pkg;

	localparam int WINDOW_DEF = 10;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] REG_IMU_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POT_THRESHOLD = 1'd1;

	localparam logic [14:0] IMU_THRESHOLD_RST = 15'd410;
	localparam logic [9:0]  POT_THRESHOLD_RST = 10'd50;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic [9:0]         pot_reading;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] avg_x;
		logic signed [15:0] avg_y;
		logic [9:0]         reported_pot;
	} result_t;

	// Pipeline strobes handed to each axis lane
	typedef struct packed {
		logic acc;    // sample beat accepted
		logic close;  // accepted beat ends the batch
		logic adv2;   // batch sum moves from s1 to s2
		logic upd;    // report issued, refresh last value
	} lane_ctrl_t;

endpackage

// File: hdl/bacr_lane.sv
`timescale 1ns / 1ps

module bacr_lane import bacr_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lane_ctrl_t         ctrl,
	input  logic signed [15:0] sample,
	input  logic [14:0]        imu_threshold,
	output logic signed [15:0] avg,
	output logic               changed
);

	localparam int LOG_W = $clog2(WINDOW);
	localparam int SUM_W = 16 + LOG_W;
	localparam int MUL_W = SUM_W + 1;
	localparam int SHIFT = SUM_W + LOG_W;
	localparam longint RECIP = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
	localparam logic [MUL_W-1:0] RECIP_C = MUL_W'(RECIP);

	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] sum_next;
	logic signed [SUM_W-1:0] sum_s1;
	logic [SUM_W-1:0]        mag;
	logic [SUM_W+MUL_W-1:0]  prod;
	logic [15:0]             quo_s2;
	logic                    neg_s2;
	logic signed [15:0]      last_q;
	logic signed [16:0]      diff;
	logic [15:0]             adiff;

	assign sum_next = sum_q + SUM_W'(sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.acc) begin
			sum_q <= ctrl.close ? '0 : sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.close) begin
			sum_s1 <= sum_next;
		end
	end

	// truncating divide: magnitude times reciprocal, sign restored in s3
	assign mag  = sum_s1[SUM_W-1] ? (~sum_s1 + 1'b1) : sum_s1;
	assign prod = (SUM_W+MUL_W)'(mag) * (SUM_W+MUL_W)'(RECIP_C);

	always_ff @(posedge clk) begin
		if (ctrl.adv2) begin
			quo_s2 <= prod[SHIFT +: 16];
			neg_s2 <= sum_s1[SUM_W-1];
		end
	end

	assign avg     = neg_s2 ? -$signed(quo_s2) : $signed(quo_s2);
	assign diff    = 17'(avg) - 17'(last_q);
	assign adiff   = diff[16] ? 16'(-diff) : diff[15:0];
	assign changed = adiff > 16'(imu_threshold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (ctrl.upd) begin
			last_q <= avg;
		end
	end

endmodule

// File: hdl/bacr_merge.sv
`timescale 1ns / 1ps

module bacr_merge import bacr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic               changed_x,
	input  logic               changed_y,
	input  logic signed [15:0] avg_x,
	input  logic signed [15:0] avg_y,
	input  logic [9:0]         pot,
	input  logic [9:0]         pot_threshold,
	input  logic               result_ready,
	output logic               result_valid,
	output result_t            result,
	output logic               upd
);

	logic [9:0]  last_pot_q;
	logic [10:0] pdiff;
	logic [9:0]  apdiff;
	logic        pot_changed;
	logic        valid_q;
	result_t     result_q;

	assign pdiff       = {1'b0, pot} - {1'b0, last_pot_q};
	assign apdiff      = pdiff[10] ? 10'(-pdiff) : pdiff[9:0];
	assign pot_changed = apdiff > pot_threshold;
	assign upd         = fire && (changed_x || changed_y || pot_changed);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			last_pot_q <= '0;
		end else begin
			if (upd) begin
				valid_q    <= 1'b1;
				last_pot_q <= pot;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			result_q.avg_x        <= avg_x;
			result_q.avg_y        <= avg_y;
			result_q.reported_pot <= pot;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

// File: hdl/block_average_change_reporter.sv
// Boxcar averager with deadband reporting for an X/Y accelerometer and a pot.
// sample channel (sample_valid/sample_ready/sample): one X/Y sample plus a
//   pot reading per beat; the pot is used only on the beat that closes a batch.
// result channel (result_valid/result_ready/result): averages and pot, sent
//   only when a batch differs from the last report by more than a threshold.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//   index 0 = imu_threshold (15 bits), index 1 = pot_threshold (low 10 bits).
// Throughput: one sample beat per cycle while sample_ready is high (see Stall).
// Pipeline: a closing beat's batch is registered through s1 (batch sum), s2
//   (reciprocal multiply) and s3 (compare and output register); a stall can
//   hold it in s1 or s2.
// Reset: sums, count and last reported values clear; thresholds load 410 and
//   50. No result is pending.
// Stall: a held result parks in the output register while the pipeline keeps
//   taking beats; sample_ready only drops when s1 and s2 both hold batches
//   and the output is blocked. It then holds off every beat, mid-batch ones
//   included, until the output drains.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module block_average_change_reporter import bacr_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  sample_t               sample,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);

	logic [14:0]      imu_thr_q;
	logic [9:0]       pot_thr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             v_s1;
	logic             v_s2;
	logic [9:0]       pot_s1;
	logic [9:0]       pot_s2;
	logic             acc;
	logic             close;
	logic             adv2;
	logic             fire3;
	logic             upd;
	lane_ctrl_t       ctrl;
	logic signed [15:0] avg_x;
	logic signed [15:0] avg_y;
	logic             changed_x;
	logic             changed_y;

	// Config registers; writes land any cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			imu_thr_q <= IMU_THRESHOLD_RST;
			pot_thr_q <= POT_THRESHOLD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMU_THRESHOLD: imu_thr_q <= cfg_data[14:0];
				REG_POT_THRESHOLD: pot_thr_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// Pipeline flow: s3 fires when the output register is free or draining
	assign fire3        = v_s2 && (!result_valid || result_ready);
	assign adv2         = v_s1 && (!v_s2 || fire3);
	assign sample_ready = !v_s1 || adv2;
	assign acc          = sample_valid && sample_ready;
	assign close        = acc && (cnt_q == CNT_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			if (close) begin
				cnt_q <= '0;
			end else if (acc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (close) begin
				v_s1 <= 1'b1;
			end else if (adv2) begin
				v_s1 <= 1'b0;
			end
			if (adv2) begin
				v_s2 <= 1'b1;
			end else if (fire3) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (close) begin
			pot_s1 <= sample.pot_reading;
		end
		if (adv2) begin
			pot_s2 <= pot_s1;
		end
	end

	assign ctrl = '{acc: acc, close: close, adv2: adv2, upd: upd};

	bacr_lane #(.WINDOW(WINDOW)) u_lane_x (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.sample        (sample.accel_x),
		.imu_threshold (imu_thr_q),
		.avg           (avg_x),
		.changed       (changed_x)
	);

	bacr_lane #(.WINDOW(WINDOW)) u_lane_y (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.sample        (sample.accel_y),
		.imu_threshold (imu_thr_q),
		.avg           (avg_y),
		.changed       (changed_y)
	);

	bacr_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire3),
		.changed_x     (changed_x),
		.changed_y     (changed_y),
		.avg_x         (avg_x),
		.avg_y         (avg_y),
		.pot           (pot_s2),
		.pot_threshold (pot_thr_q),
		.result_ready  (result_ready),
		.result_valid  (result_valid),
		.result        (result),
		.upd           (upd)
	);

	`ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CNT_LAST, "batch counter out of range")
	`ASSERT_NEXT(a_s2_hold, v_s2 && !fire3, v_s2, "s2 batch lost while stalled")
	`ASSERT_NEXT(a_report_lands, upd, result_valid, "report did not reach output")
	`ASSERT_IMP(a_upd_only_on_fire, upd, fire3, "report issued without s3 fire")

endmodule
